FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

   localparam int DATA_W              = 32;
   localparam int STATUS_W            = 2;
   localparam int OCC_W               = 5;
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic                     insert;
      logic                     remove;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

FILE: sv/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                              clock,
   input  spq_pkg::cell_cmd_type             cmd,
   input  logic [CW-1:0]                     count,
   input  logic signed [spq_pkg::DATA_W-1:0] left_value,
   input  logic                              left_gt,
   input  logic signed [spq_pkg::DATA_W-1:0] right_value,
   output logic signed [spq_pkg::DATA_W-1:0] value,
   output logic                              gt
);
   import spq_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     valid;

   assign valid = CW'(IDX) < count;
   // strictly greater than the new value: insertion lands before this cell
   assign gt    = valid && (value_ff > cmd.value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt || !valid) begin
            value_in = cmd.value;
         end
      end else if (cmd.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue: ascending order, ties leave in arrival order.
// The result of a request strobes on rsp_strobe in the cycle after it is taken.
// Throughput: one request per cycle; every cell of the chain compares and shifts in parallel.
// Reset (synchronous, active high) empties the queue and drops any pending strobe;
// busy is high only while reset is held. The receiver cannot stall results.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_out_value,
   output logic        [spq_pkg::STATUS_W-1:0] rsp_status,
   output logic        [spq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import spq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                     accept;
   logic                     full;
   logic                     empty;
   cell_cmd_type             cmd;

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;

   logic                     strobe_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic signed [DATA_W-1:0] out_value_in;
   logic [STATUS_W-1:0]      status_ff;
   logic [STATUS_W-1:0]      status_in;

   // per-cell taps of the chain
   logic signed [DATA_W-1:0] cell_value [QUEUE_DEPTH];
   logic                     cell_gt    [QUEUE_DEPTH];

   assign busy   = reset;
   assign accept = start && !busy;
   assign full   = count_ff == CW'(QUEUE_DEPTH);
   assign empty  = count_ff == '0;

   // a dropped insert or an empty remove leaves the chain untouched
   assign cmd.insert = accept && (req_op == OP_INSERT) && !full;
   assign cmd.remove = accept && (req_op == OP_REMOVE) && !empty;
   assign cmd.value  = req_value;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic signed [DATA_W-1:0] left_value;
         logic                     left_gt;
         logic signed [DATA_W-1:0] right_value;

         if (g == 0) begin : g_head
            assign left_value = '0;
            assign left_gt    = 1'b0;
         end else begin : g_mid
            assign left_value = cell_value[g-1];
            assign left_gt    = cell_gt[g-1];
         end

         // tail cell keeps its own value on remove; it becomes invalid anyway
         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_value = cell_value[g];
         end else begin : g_body
            assign right_value = cell_value[g+1];
         end

         spq_cell #(
            .IDX (g),
            .CW  (CW)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .count       (count_ff),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .right_value (right_value),
            .value       (cell_value[g]),
            .gt          (cell_gt[g])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      out_value_in = '0;
      status_in    = STATUS_OK;
      if (accept) begin
         if (req_op == OP_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               // head cell always holds the smallest value
               out_value_in = cell_value[0];
               count_in     = count_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
      out_value_ff <= out_value_in;
      status_ff    <= status_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = OCC_W'(count_ff);

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request taken without a result strobe");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result strobe without a request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the queue");

   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != STATUS_OK |-> $stable(count_ff))
      else $error("failed request changed the entry count");

endmodule

FILE: verif/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue: a scoreboard class predicts every
// response from its own copy of the sorted store; plain tasks drive requests.
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH           = DEFAULT_QUEUE_DEPTH;
   localparam int PHASE_REQUESTS  = 375;   // three random phases, ~1150 requests in all
   localparam int DRAIN_INTERVAL  = 150;   // sender pauses until every owed response is back this often

   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   // one response as the block should present it
   typedef struct {
      logic signed [DATA_W-1:0] out_value;
      logic [STATUS_W-1:0]      status;
      logic [OCC_W-1:0]         occupancy;
   } queue_response_type;

   // ------------------------------------------------------------------
   // Scoreboard: holds the predicted sorted contents and the responses
   // still owed by the block, oldest first.
   // ------------------------------------------------------------------
   class sorted_queue_checker;
      logic signed [DATA_W-1:0] entries [DEPTH];
      int                       count;
      queue_response_type       awaited [$];
      int                       mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      // update the predicted store for a taken request and queue its response
      function void note_request(logic op, logic signed [DATA_W-1:0] value);
         queue_response_type r;
         int pos;
         int i;
         r.out_value = '0;
         r.status    = STATUS_OK;
         if (op == OP_INSERT) begin
            if (count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // new value goes before the first strictly greater entry,
               // so equal values keep their arrival order
               pos = count;
               for (i = 0; i < count; i++)
                  if (entries[i] > value && pos == count) pos = i;
               for (i = count; i > pos; i--)
                  entries[i] = entries[i-1];
               entries[pos] = value;
               count++;
            end
         end else begin
            if (count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.out_value = entries[0];
               for (i = 1; i < count; i++)
                  entries[i-1] = entries[i];
               count--;
            end
         end
         r.occupancy = OCC_W'(count);
         awaited.insert(awaited.size(), r);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_response(logic signed [DATA_W-1:0] out_value, logic [STATUS_W-1:0] status,
                          logic [OCC_W-1:0] occupancy);
         queue_response_type want;
         if (awaited.size() == 0) begin
            report_mismatch("response with no request pending", longint'(out_value), 0);
         end else begin
            want = awaited[0];
            awaited.delete(0);
            if (out_value !== want.out_value)
               report_mismatch("out_value", longint'(out_value), longint'(want.out_value));
            if (status !== want.status)
               report_mismatch("status", status, want.status);
            if (occupancy !== want.occupancy)
               report_mismatch("occupancy", occupancy, want.occupancy);
         end
      endtask
   endclass

   // ------------------------------------------------------------------
   // DUT and clocking
   // ------------------------------------------------------------------
   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        start     = 1'b0;
   logic                        req_op    = OP_INSERT;
   logic signed [DATA_W-1:0]    req_value = '0;
   logic                        busy;
   logic                        rsp_strobe;
   logic signed [DATA_W-1:0]    rsp_out_value;
   logic        [STATUS_W-1:0]  rsp_status;
   logic        [OCC_W-1:0]     rsp_occupancy;

   sorted_queue_checker chk;
   int                  idle_pct;   // chance in a hundred that a sender cycle is idle

   always #2 clock = ~clock;

   sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   // Monitor. Everything is sampled at the rising edge. A strobe seen here
   // belongs to an earlier request, so it is checked before the request taken
   // at this same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) chk.check_response(rsp_out_value, rsp_status, rsp_occupancy);
         if (start && !busy) chk.note_request(req_op, req_value);
      end
   end

   // ------------------------------------------------------------------
   // Driver tasks: inputs move only on the falling edge.
   // ------------------------------------------------------------------

   // Idle cycle by cycle (with junk on the request lines) at the chosen rate,
   // then present the request and hold it until it is taken. start stays high
   // on return so back-to-back requests run at full rate.
   task automatic send_request(logic op, logic signed [DATA_W-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start     <= 1'b0;
         req_op    <= 1'($urandom_range(0, 1));
         req_value <= $urandom();
      end
      @(negedge clock);
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   // sender holds off until every owed response has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (chk.awaited.size() != 0) @(negedge clock);
   endtask

   // value mix: extremes, a narrow band to force ties, and full-range noise
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2, 3, 4: return DATA_W'(int'($urandom_range(0, 8)) - 4);
         default: return $urandom();
      endcase
   endfunction

   // Directed: remove while empty, extremes and ties, fill to capacity,
   // insert while full (dropped), then partly drain.
   task automatic run_directed();
      int i;
      idle_pct = 0;
      send_request(OP_REMOVE, 32'h1234_5678);   // empty queue, value ignored
      send_request(OP_INSERT, VAL_MAX);
      send_request(OP_INSERT, VAL_MIN);
      send_request(OP_INSERT, 0);
      send_request(OP_INSERT, -1);
      send_request(OP_INSERT, 1);
      send_request(OP_INSERT, 32'h5555_5555);
      send_request(OP_INSERT, 32'hAAAA_AAAA);
      send_request(OP_INSERT, -1);               // tie with an earlier entry
      send_request(OP_INSERT, 0);
      send_request(OP_INSERT, 7);
      send_request(OP_INSERT, 7);
      send_request(OP_INSERT, VAL_MAX);          // tie at the top
      send_request(OP_INSERT, VAL_MIN);          // tie at the bottom
      send_request(OP_INSERT, -100);
      send_request(OP_INSERT, 100);
      send_request(OP_INSERT, 3);                // sixteenth entry: now full
      send_request(OP_INSERT, 42);               // dropped, status full
      for (i = 0; i < 7; i++)
         send_request(OP_REMOVE, $urandom());
   endtask

   // Random: the insert bias changes every 40 requests so the store keeps
   // swinging between empty and full.
   task automatic run_random(int requests, int pct);
      int k;
      int insert_pct;
      idle_pct   = pct;
      insert_pct = 50;
      for (k = 0; k < requests; k++) begin
         if (k % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 15;
               1:       insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         if (k % DRAIN_INTERVAL == DRAIN_INTERVAL - 1) wait_drained();
         send_request(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                      pick_value());
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      chk = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      run_random(PHASE_REQUESTS, 22);
      run_random(PHASE_REQUESTS, 75);
      run_random(PHASE_REQUESTS, 0);

      // all requests taken: wait for the last response, then idle on to catch any stray strobe
      wait_drained();
      repeat (4) @(posedge clock);

      if (chk.mismatches == 0 && chk.awaited.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog: a correct run needs well under a tenth of this
   initial begin
      #400_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
